// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent, then consequent starting on the next cycle
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent, then consequent in the same cycle
`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/mfa_pkg.sv
// ----------------------------------------------------------------------------
// mfa_pkg
// Constants and stage types for the minifloat adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfa_pkg;

    localparam int WORD_W = 15;
    localparam int EXP_W  = 5;
    localparam int FRAC_W = 9;
    localparam int SIGN_POS = 14;
    localparam int MAG_W  = 41;
    localparam int POS_W  = 6;

    localparam logic [EXP_W-1:0]  EXP_MAX  = 5'h1F;
    localparam logic [WORD_W-1:0] POS_ZERO = 15'h0000;
    localparam logic [WORD_W-1:0] NEG_ZERO = 15'h4000;
    localparam logic [WORD_W-1:0] POS_INF  = 15'h3E00;
    localparam logic [WORD_W-1:0] POS_NAN  = 15'h3E01;
    localparam logic [WORD_W-1:0] NEG_NAN  = 15'h7E01;

    typedef struct packed {
        logic               special;
        logic [WORD_W-1:0]  code;
        logic               sign;
        logic [MAG_W-1:0]   mag;
        logic [EXP_W-1:0]   emin;
    } s1_t;

endpackage

// File: sv/mfa_align.sv
// ----------------------------------------------------------------------------
// mfa_align
// Special-case resolution, significand alignment and signed add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfa_align (
    input  logic [mfa_pkg::WORD_W-1:0] operand_a,
    input  logic [mfa_pkg::WORD_W-1:0] operand_b,
    output mfa_pkg::s1_t               s1
);
    import mfa_pkg::*;

    logic              sa, sb;
    logic [EXP_W-1:0]  ea, eb, diff;
    logic [MAG_W-2:0]  ma, mb;
    logic [MAG_W:0]    va, vb, sum, neg;
    logic              a_gt;

    always_comb
    begin
        sa   = operand_a[SIGN_POS];
        sb   = operand_b[SIGN_POS];
        ea   = operand_a[SIGN_POS-1:FRAC_W];
        eb   = operand_b[SIGN_POS-1:FRAC_W];
        a_gt = ea > eb;
        diff = a_gt ? ea - eb : eb - ea;
        ma   = {{(MAG_W-2-FRAC_W){1'b0}}, 1'b1, operand_a[FRAC_W-1:0]};
        mb   = {{(MAG_W-2-FRAC_W){1'b0}}, 1'b1, operand_b[FRAC_W-1:0]};
        if (a_gt)
            ma = ma << diff;
        else
            mb = mb << diff;
        va  = sa ? -{2'b00, ma} : {2'b00, ma};
        vb  = sb ? -{2'b00, mb} : {2'b00, mb};
        sum = va + vb;
        neg = -sum;

        s1.sign = sum[MAG_W];
        s1.mag  = sum[MAG_W] ? neg[MAG_W-1:0] : sum[MAG_W-1:0];
        s1.emin = a_gt ? eb : ea;

        s1.special = 1'b1;
        if (operand_a == POS_NAN || operand_a == NEG_NAN)
            s1.code = operand_a;
        else if (operand_b == POS_NAN || operand_b == NEG_NAN)
            s1.code = operand_b;
        else if (ea == EXP_MAX && eb == EXP_MAX)
            s1.code = (operand_a == operand_b) ? operand_a : POS_NAN;
        else if (ea == EXP_MAX)
            s1.code = operand_a;
        else if (eb == EXP_MAX)
            s1.code = operand_b;
        else if (operand_a == POS_ZERO)
            s1.code = (operand_b == NEG_ZERO) ? operand_a : operand_b;
        else if (operand_b == POS_ZERO)
            s1.code = (operand_a == NEG_ZERO) ? operand_b : operand_a;
        else if (operand_a == NEG_ZERO)
            s1.code = operand_b;
        else if (operand_b == NEG_ZERO)
            s1.code = operand_a;
        else if (sum == '0)
            s1.code = POS_ZERO;
        else
        begin
            s1.special = 1'b0;
            s1.code    = POS_ZERO;
        end
    end

endmodule

// File: sv/mfa_norm.sv
// ----------------------------------------------------------------------------
// mfa_norm
// Leading-one search, truncating normalize, flush and saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfa_norm (
    input  mfa_pkg::s1_t               s1,
    output logic [mfa_pkg::WORD_W-1:0] result
);
    import mfa_pkg::*;

    logic [POS_W-1:0] p;
    logic [MAG_W-1:0] shifted;
    logic signed [7:0] e;

    always_comb
    begin
        p = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (s1.mag[i])
                p = POS_W'(i);
        end
        shifted = s1.mag << (POS_W'(MAG_W - 1) - p);
        e = $signed({3'b000, s1.emin}) + $signed({2'b00, p}) - 8'sd9;

        if (s1.special)
            result = s1.code;
        else if (e <= 8'sd0)
            result = s1.sign ? NEG_ZERO : POS_ZERO;
        else if (e >= 8'sd31)
            result = s1.sign ? (NEG_ZERO | POS_INF) : POS_INF;
        else
            result = {s1.sign, e[EXP_W-1:0], shifted[MAG_W-2 -: FRAC_W]};
    end

endmodule

// File: sv/minifloat_adder.sv
// ----------------------------------------------------------------------------
// minifloat_adder
// Adds two 15-bit minifloats (1 sign, 5 exponent bias 15, 9 fraction).
// ----------------------------------------------------------------------------
// Usage:
//   Drive operand_a and operand_b and pulse start; a request is taken at any
//   rising edge with start high, and busy is always low, so a new request
//   may be issued every cycle.
//   Each request produces one result: sum_value is valid for exactly one
//   cycle while done is high, once the request has passed through the input
//   register, the align/add register and the result register in that order.
//   Throughput is one request per cycle.
//   Results come out in request order. The receiver cannot stall; it must
//   take each result in the cycle done is high.
//   Reset clears all valid flags; requests in flight are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module minifloat_adder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [mfa_pkg::WORD_W-1:0] operand_a,
    input  logic [mfa_pkg::WORD_W-1:0] operand_b,
    output logic                       done,
    output logic [mfa_pkg::WORD_W-1:0] sum_value
);
    import mfa_pkg::*;

    logic              in_valid_reg, s1_valid_reg, out_valid_reg;
    logic [WORD_W-1:0] a_reg, b_reg, out_reg;
    s1_t               s1_next, s1_reg;
    logic [WORD_W-1:0] out_next;

    mfa_align u_align (
        .operand_a (a_reg),
        .operand_b (b_reg),
        .s1        (s1_next)
    );

    mfa_norm u_norm (
        .s1     (s1_reg),
        .result (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            s1_valid_reg  <= in_valid_reg;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    assign busy      = 1'b0;
    assign done      = out_valid_reg;
    assign sum_value = out_reg;

    `AST_NEXT(a_in_to_s1, in_valid_reg, s1_valid_reg, "request lost after input stage")
    `AST_NEXT(a_s1_to_out, s1_valid_reg, done, "request lost before result")
    `AST_NEXT(a_nan_a, in_valid_reg && a_reg == POS_NAN, ##1 (done && sum_value == POS_NAN), "NaN not propagated")
    `AST_SAME(a_special_code, s1_valid_reg && s1_reg.special && s1_reg.code == POS_NAN, out_next == POS_NAN, "special bypass broken")

endmodule

// File: sim/minifloat_adder_tb.sv
// ----------------------------------------------------------------------------
// minifloat_adder_tb
// Self-checking bench for the minifloat adder: a directed table of operand
// pairs followed by random requests, each sum compared against a behavioral
// adder model in request order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module minifloat_adder_tb;
    import mfa_pkg::*;

    localparam int N_RANDOM  = 1850;
    localparam int WDOG_MAX  = 2000;
    localparam int DRAIN_CYC = 10;

    typedef struct {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              known;
        logic [WORD_W-1:0] sum;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
    logic              done;
    logic [WORD_W-1:0] sum_value;

    logic [WORD_W-1:0] sum_queue[$];
    int                errors;
    int                idle_cycles;
    bit                quiet;

    minifloat_adder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .done      (done),
        .sum_value (sum_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] add_minifloat(logic [WORD_W-1:0] a,
                                                      logic [WORD_W-1:0] b);
        logic [EXP_W-1:0] ea, eb, emin;
        logic             sa, sb, s;
        logic [63:0]      ma, mb, mag;
        longint           sum;
        int               p, e;
        ea = a[13:9];
        eb = b[13:9];
        sa = a[SIGN_POS];
        sb = b[SIGN_POS];
        if (a == POS_NAN || a == NEG_NAN) return a;
        if (b == POS_NAN || b == NEG_NAN) return b;
        if (ea == EXP_MAX && eb == EXP_MAX) return (a == b) ? a : POS_NAN;
        if (ea == EXP_MAX) return a;
        if (eb == EXP_MAX) return b;
        if (a == POS_ZERO) return (b == NEG_ZERO) ? a : b;
        if (b == POS_ZERO) return (a == NEG_ZERO) ? b : a;
        if (a == NEG_ZERO) return b;
        if (b == NEG_ZERO) return a;
        ma = {54'd0, 1'b1, a[8:0]};
        mb = {54'd0, 1'b1, b[8:0]};
        if (ea > eb) ma = ma << (ea - eb);
        else mb = mb << (eb - ea);
        emin = (ea > eb) ? eb : ea;
        sum = (sa ? -longint'(ma) : longint'(ma)) + (sb ? -longint'(mb) : longint'(mb));
        if (sum == 0) return POS_ZERO;
        s = (sum < 0);
        mag = (sum < 0) ? 64'(-sum) : 64'(sum);
        p = 0;
        while (p < 63 && (mag >> (p + 1)) != 0) p++;
        e = int'(emin) + p - FRAC_W;
        if (p > FRAC_W) mag = mag >> (p - FRAC_W);
        else mag = mag << (FRAC_W - p);
        if (e <= 0) return s ? NEG_ZERO : POS_ZERO;
        if (e >= 31) return s ? (NEG_ZERO | POS_INF) : POS_INF;
        return {s, e[4:0], mag[8:0]};
    endfunction

    // one request per call; idles at random unless quiet
    task automatic send_request(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        while (!quiet && $urandom_range(99) < 14)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        sum_queue.push_back(add_minifloat(a, b));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sum_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] rand_operand();
        logic [WORD_W-1:0] v;
        v = WORD_W'($urandom_range(32'h7FFF));
        case ($urandom_range(9))
            0: v[13:9] = EXP_MAX;
            1: v = $urandom_range(1) ? POS_ZERO : NEG_ZERO;
            2: v = $urandom_range(1) ? POS_NAN : NEG_NAN;
            3: v[13:9] = $urandom_range(1) ? 5'd0 : 5'd1;
            4: v[13:9] = 5'd29 + EXP_W'($urandom_range(1));
            default: ;
        endcase
        return v;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (sum_queue.size() == 0)
            begin
                $error("unexpected result sum_value=%h", sum_value);
                errors++;
            end
            else if (sum_value !== sum_queue[0])
            begin
                $error("sum_value mismatch: expected %h actual %h", sum_queue[0], sum_value);
                errors++;
                void'(sum_queue.pop_front());
            end
            else
                void'(sum_queue.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        dir_row_t        rows[$];
        logic [WORD_W-1:0] x, y;
        errors      = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        operand_a   = '0;
        operand_b   = '0;
        rows = '{
            '{15'h3E01, 15'h7E01, 1, 15'h3E01},
            '{15'h1234, 15'h7E01, 1, 15'h7E01},
            '{15'h3E05, 15'h3E05, 1, 15'h3E05},
            '{15'h3E05, 15'h7E00, 1, 15'h3E01},
            '{15'h7E00, 15'h1234, 1, 15'h7E00},
            '{15'h0123, 15'h3FFF, 1, 15'h3FFF},
            '{15'h0000, 15'h4000, 1, 15'h0000},
            '{15'h4000, 15'h0000, 1, 15'h0000},
            '{15'h4000, 15'h4000, 1, 15'h4000},
            '{15'h0000, 15'h1E00, 1, 15'h1E00},
            '{15'h5E00, 15'h4000, 1, 15'h5E00},
            '{15'h1E00, 15'h5E00, 1, 15'h0000},
            '{15'h0000, 15'h0000, 1, 15'h0000},
            '{15'h3DFF, 15'h3DFF, 1, 15'h3E00},
            '{15'h7DFF, 15'h7DFF, 1, 15'h7E00},
            '{15'h0201, 15'h4200, 1, 15'h0000},
            '{15'h4201, 15'h0200, 1, 15'h4000},
            '{15'h7FFF, 15'h3FFF, 0, 15'h0},
            '{15'h01FF, 15'h41FE, 0, 15'h0},
            '{15'h1E00, 15'h1C00, 0, 15'h0},
            '{15'h3DFF, 15'h0001, 0, 15'h0},
            '{15'h5555, 15'h2AAA, 0, 15'h0},
            '{15'h2AAA, 15'h5555, 0, 15'h0}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            if (rows[i].known && add_minifloat(rows[i].a, rows[i].b) !== rows[i].sum)
            begin
                $error("table row %0d sum_value: expected %h actual %h", i, rows[i].sum,
                       add_minifloat(rows[i].a, rows[i].b));
                errors++;
            end
            send_request(rows[i].a, rows[i].b);
        end
        wait_drained();
        for (int n = 0; n < N_RANDOM; n++)
        begin
            quiet = (n >= 600 && n < 900);
            x = rand_operand();
            y = rand_operand();
            // near cancellation pairs
            if ($urandom_range(7) == 0)
            begin
                y = x ^ 15'h4000;
                y[3:0] = 4'($urandom_range(15));
            end
            send_request(x, y);
            if (n == 1200) wait_drained();
        end
        wait_drained();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
